@@ rtl/core/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life grid generation engine: command
// codes, the B3/S23 neighbor counts and default grid dimensions.
// ----------------------------------------------------------------------------
package lge_pkg;

   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;

   // neighbor counts of the B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_STEP  = 2'd3
   } cmd_type;

endpackage

@@ rtl/core/life_grid_generation_engine_top.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_engine_top
// Game of Life engine on a bounded grid: cell set, clear and query commands
// and whole-generation steps over two row-wide ping-pong memories.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; every command
// returns exactly one beat on rsp_valid, held for one cycle only, since the
// receiver cannot stall. After reset the block runs a clearing pass over
// every row of both grids with busy high. A set, clear or query keeps busy
// high while its row is read, then modified and written back, and its result
// shows in the cycle after that; no new command is taken while busy is high.
// A generation step keeps busy high until every next row is written, and its
// result shows in the cycle after that: the current grid is read one row per
// cycle through its single read port, a three-row window feeds the rule
// logic, and each next row is written to the other grid once the row below
// it has been read back; the grids swap at the end.
// Cells outside the grid count as dead, and addresses outside the grid are
// ignored on writes and read as dead.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_top #(
   parameter int GRID_WIDTH  = lge_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = lge_pkg::DEF_GRID_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_command,
   input  logic [5:0] req_cell_x,
   input  logic [5:0] req_cell_y,
   output logic       rsp_valid,
   output logic       rsp_cell_alive,
   output logic       rsp_command_done
);

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int CNT_W = $clog2(GRID_HEIGHT + 2);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CELL  = 5'b00100,
      ST_GEN   = 5'b01000,
      ST_SPARE = 5'b10000
   } state_type;

   // grid storage
   logic [GRID_WIDTH-1:0] grid_a_mem [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] grid_b_mem [GRID_HEIGHT];

   state_type             state_ff, state_in;
   logic                  sel_ff, sel_in;
   logic [ROW_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]      gen_cnt_ff, gen_cnt_in;
   lge_pkg::cmd_type      cmd_ff, cmd_in;
   logic                  in_range_ff, in_range_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [GRID_WIDTH-1:0] above_ff, above_in;
   logic [GRID_WIDTH-1:0] here_ff, here_in;
   logic [GRID_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_alive_ff, rsp_alive_in;

   logic                  accept;
   logic                  req_in_range;
   logic [ROW_W-1:0]      rd_addr;
   logic [ROW_W-1:0]      wr_addr;
   logic [GRID_WIDTH-1:0] wr_data;
   logic                  a_we, b_we;
   logic                  cell_we, gen_we, clr_we;
   logic [GRID_WIDTH-1:0] cur_row;
   logic [GRID_WIDTH-1:0] edit_row;
   logic [GRID_WIDTH-1:0] below_row;
   logic [GRID_WIDTH-1:0] next_row;
   logic                  gen_last;
   logic                  gen_reading;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign req_in_range = (int'(req_cell_x) < GRID_WIDTH) && (int'(req_cell_y) < GRID_HEIGHT);
   assign cur_row      = sel_ff ? rd_b_ff : rd_a_ff;
   assign gen_last     = (gen_cnt_ff == CNT_W'(GRID_HEIGHT + 1));
   assign gen_reading  = (int'(gen_cnt_ff) < GRID_HEIGHT);
   // rows past the bottom edge are dead
   assign below_row    = gen_reading || (int'(gen_cnt_ff) == GRID_HEIGHT) ?
                         cur_row : '0;

   // read address: the addressed row on accept, the row stream during a step
   always_comb begin
      rd_addr = '0;
      if (state_ff == ST_GEN) begin
         if (gen_reading) rd_addr = gen_cnt_ff[ROW_W-1:0];
      end else if (req_in_range) begin
         rd_addr = ROW_W'(req_cell_y);
      end
   end

   // cell edit on the fetched row
   always_comb begin
      edit_row = cur_row;
      if (cmd_ff == lge_pkg::CMD_SET) begin
         edit_row[col_ff] = 1'b1;
      end else if (cmd_ff == lge_pkg::CMD_CLEAR) begin
         edit_row[col_ff] = 1'b0;
      end
   end

   // B3/S23 rule over the three-row window, zero padded at the side edges
   always_comb begin
      logic [GRID_WIDTH+1:0] pad_a;
      logic [GRID_WIDTH+1:0] pad_h;
      logic [GRID_WIDTH+1:0] pad_b;
      logic [3:0]            cnt;
      pad_a = {1'b0, above_ff, 1'b0};
      pad_h = {1'b0, here_ff, 1'b0};
      pad_b = {1'b0, below_row, 1'b0};
      next_row = '0;
      for (int x = 0; x < GRID_WIDTH; x++) begin
         cnt = 4'(pad_a[x]) + 4'(pad_a[x+1]) + 4'(pad_a[x+2])
             + 4'(pad_h[x]) + 4'(pad_h[x+2])
             + 4'(pad_b[x]) + 4'(pad_b[x+1]) + 4'(pad_b[x+2]);
         next_row[x] = (cnt == lge_pkg::BIRTH_COUNT) ||
                       ((cnt == lge_pkg::SURVIVE_COUNT) && pad_h[x+1]);
      end
   end

   // write port shared by both grids, enables pick the target
   assign clr_we  = (state_ff == ST_CLEAR);
   assign cell_we = (state_ff == ST_CELL) && in_range_ff && (cmd_ff != lge_pkg::CMD_QUERY);
   assign gen_we  = (state_ff == ST_GEN) && (gen_cnt_ff >= CNT_W'(2));
   assign a_we    = clr_we || (cell_we && !sel_ff) || (gen_we && sel_ff);
   assign b_we    = clr_we || (cell_we && sel_ff) || (gen_we && !sel_ff);

   always_comb begin
      wr_addr = '0;
      wr_data = '0;
      if (clr_we) begin
         wr_addr = clr_cnt_ff;
      end else if (state_ff == ST_CELL) begin
         wr_addr = row_ff;
         wr_data = edit_row;
      end else begin
         wr_addr = ROW_W'(gen_cnt_ff - CNT_W'(2));
         wr_data = next_row;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) grid_a_mem[wr_addr] <= wr_data;
      rd_a_ff <= grid_a_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) grid_b_mem[wr_addr] <= wr_data;
      rd_b_ff <= grid_b_mem[rd_addr];
   end

   // control
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      clr_cnt_in   = clr_cnt_ff;
      gen_cnt_in   = gen_cnt_ff;
      cmd_in       = cmd_ff;
      in_range_in  = in_range_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      above_in     = above_ff;
      here_in      = here_ff;
      rsp_valid_in = 1'b0;
      rsp_alive_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ROW_W'(1);
            if (int'(clr_cnt_ff) == GRID_HEIGHT - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = lge_pkg::cmd_type'(req_command);
               in_range_in = req_in_range;
               row_in      = req_in_range ? ROW_W'(req_cell_y) : '0;
               col_in      = req_in_range ? COL_W'(req_cell_x) : '0;
               above_in    = '0;
               here_in     = '0;
               gen_cnt_in  = '0;
               state_in    = (req_command == lge_pkg::CMD_STEP) ? ST_GEN : ST_CELL;
            end
         end
         ST_CELL: begin
            rsp_valid_in = 1'b1;
            rsp_alive_in = in_range_ff && edit_row[col_ff];
            state_in     = ST_IDLE;
         end
         ST_GEN: begin
            gen_cnt_in = gen_cnt_ff + CNT_W'(1);
            // slide the window once row data is coming back
            if (gen_cnt_ff != '0) begin
               above_in = here_ff;
               here_in  = below_row;
            end
            if (gen_last) begin
               sel_in       = !sel_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sel_ff       <= 1'b0;
         clr_cnt_ff   <= '0;
         gen_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         clr_cnt_ff   <= clr_cnt_in;
         gen_cnt_ff   <= gen_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      in_range_ff  <= in_range_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      above_ff     <= above_in;
      here_ff      <= here_in;
      rsp_alive_ff <= rsp_alive_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_alive   = rsp_alive_ff;
   assign rsp_command_done = rsp_valid_ff;

   // a result beat only follows a finished cell command or generation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_CELL || (state_ff == ST_GEN && gen_last)))
      else $error("result beat without a finished command");

   // no grid write while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!a_we && !b_we))
      else $error("grid write while idle");

   // a generation never writes the grid it is reading
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN) |-> ((sel_ff && !b_we) || (!sel_ff && !a_we)))
      else $error("generation writes the current grid");

endmodule
